/* src/lcfc_pkg.sv */
// lcfc_pkg: shared types and constants of the link credit flow control block
// no dependencies; used by the interfaces, all modules and the checker
package lcfc_pkg;

	// link control bytes
	localparam logic [7:0] ACK_BYTE  = 8'hF4;
	localparam logic [7:0] SYNC_BYTE = 8'hF5;

	// item kinds
	localparam logic [2:0] KIND_RX    = 3'd0;
	localparam logic [2:0] KIND_TX    = 3'd1;
	localparam logic [2:0] KIND_QUERY = 3'd2;
	localparam logic [2:0] KIND_IDLE  = 3'd3;
	localparam logic [2:0] KIND_SYNC  = 3'd4;

	// result status codes
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_FRAMING = 2'd1;
	localparam logic [1:0] STATUS_NONE    = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_ROLE_MASTER  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_EVERY    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CREDIT_LIMIT = 2'd2;

	// configuration reset values
	localparam logic [7:0] ACK_EVERY_RST    = 8'd16;
	localparam logic [7:0] CREDIT_LIMIT_RST = 8'd16;

	// field widths
	localparam int KIND_W = 3;
	localparam int BYTE_W = 8;
	localparam int FILL_W = 9;
	localparam int STATUS_W = 2;
	localparam int CMD_BYTES = 4;

	// design defaults
	localparam int TX_BUFFER_SIZE_DEF = 256;
	localparam int QUEUE_DEPTH_DEF = 4;

	// link phase, one-hot
	typedef enum logic [3:0] {
		PH_RUN         = 4'b0001,
		PH_M_WAIT_SYNC = 4'b0010,
		PH_M_WAIT_ACK  = 4'b0100,
		PH_S_WAIT_SYNC = 4'b1000
	} phase_t;

	// classified work handed from front to back
	typedef struct packed {
		logic                             tx_valid;
		logic [CMD_BYTES-1:0][BYTE_W-1:0] tx_bytes;
		logic                             data_valid;
		logic [BYTE_W-1:0]                data;
		logic [STATUS_W-1:0]              status;
		logic                             can_send;
		logic                             synced;
		logic                             multi;
	} work_t;

endpackage

/* src/lcfc_item_if.sv */
// lcfc_item_if, lcfc_result_if: valid/ready channels of the block
// depends on lcfc_pkg for field widths
interface lcfc_item_if import lcfc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [BYTE_W-1:0] rx_byte;
	logic [BYTE_W-1:0] cmd_header;
	logic [BYTE_W-1:0] cmd_byte1;
	logic [BYTE_W-1:0] cmd_byte2;
	logic [BYTE_W-1:0] cmd_byte3;
	logic [FILL_W-1:0] num_bytes;
	logic [FILL_W-1:0] tx_fill;
	logic              rx_empty;

	modport source (output valid, kind, rx_byte, cmd_header, cmd_byte1, cmd_byte2,
		cmd_byte3, num_bytes, tx_fill, rx_empty, input ready);
	modport sink (input valid, kind, rx_byte, cmd_header, cmd_byte1, cmd_byte2,
		cmd_byte3, num_bytes, tx_fill, rx_empty, output ready);
endinterface

interface lcfc_result_if import lcfc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                tx_valid;
	logic [BYTE_W-1:0]   tx_out;
	logic                data_valid;
	logic [BYTE_W-1:0]   data_out;
	logic [STATUS_W-1:0] status;
	logic                can_send;
	logic                synced;
	logic                last;

	modport source (output valid, tx_valid, tx_out, data_valid, data_out, status,
		can_send, synced, last, input ready);
	modport sink (input valid, tx_valid, tx_out, data_valid, data_out, status,
		can_send, synced, last, output ready);
endinterface

/* src/link_credit_flow_control_unit.sv */
// link_credit_flow_control_unit: top level of the link credit flow control block
// depends on lcfc_pkg, lcfc_item_if, lcfc_result_if, lcfc_front, lcfc_queue, lcfc_back
//
// usage
// - item channel (valid/ready): one item per handshake: received byte, transmit
//   command, can-transmit query, idle tick or start sync
// - result channel (valid/ready): one or more result items per input item, the
//   final one flagged by last; a transmit command gives four, every other kind one
// - cfg port: write enable, register index, 8-bit data; write only while idle
// - path: the work of a taken item is queued, then loaded into the output register
// - throughput: one result item per cycle out of the output register while the
//   receiver is ready, so one item per cycle for single-result kinds
// - link state and counts are updated by the front as the item is taken; the
//   work then waits in a four-entry queue until the back has emitted it
// - receiver stall: the output register holds; the queue fills and item ready
//   drops only when all four entries are taken
// - reset: link phase running, counts zero, role slave, ack_every and
//   credit_limit 16, queue and output register empty
module link_credit_flow_control_unit import lcfc_pkg::*; #(
	parameter int TX_BUFFER_SIZE = TX_BUFFER_SIZE_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	lcfc_item_if.sink             item,
	lcfc_result_if.source         result
);

	// front to queue
	logic  push;
	work_t push_data;
	logic  full;

	// queue to back
	logic  pop;
	work_t head;
	logic  empty;

	// classification and link state
	lcfc_front #(
		.TX_BUFFER_SIZE(TX_BUFFER_SIZE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.item      (item),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	// decouples acceptance from result emission
	lcfc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	// result sequencing and output register
	lcfc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule

/* src/lcfc_front.sv */
// lcfc_front: accepts items, holds config and link state, classifies each item
// depends on lcfc_pkg and lcfc_item_if
module lcfc_front import lcfc_pkg::*; #(
	parameter int TX_BUFFER_SIZE = TX_BUFFER_SIZE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	lcfc_item_if.sink             item,
	output logic                  push,
	output work_t                 push_data,
	input  logic                  full
);

	localparam int SizeW = $clog2(TX_BUFFER_SIZE + 1);
	localparam int CmpW = (SizeW > FILL_W) ? SizeW : FILL_W;
	localparam logic [CmpW-1:0] BufSize = CmpW'(TX_BUFFER_SIZE);

	logic              role_q;
	logic [BYTE_W-1:0] ack_every_q;
	logic [BYTE_W-1:0] credit_limit_q;
	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] recv_q, recv_d;
	logic [BYTE_W-1:0] sent_q, sent_d;
	logic [BYTE_W-1:0] recv_inc;
	logic [BYTE_W:0]   sent_add;
	logic [CmpW-1:0]   fill_e;
	logic [CmpW-1:0]   num_e;
	logic              space_ok;
	work_t             w;

	assign item.ready = !full;
	assign push = item.valid && !full;
	assign push_data = w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			role_q <= 1'b0;
			ack_every_q <= ACK_EVERY_RST;
			credit_limit_q <= CREDIT_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_ROLE_MASTER:  role_q <= cfg_wdata[0];
				CFG_ACK_EVERY:    ack_every_q <= cfg_wdata;
				CFG_CREDIT_LIMIT: credit_limit_q <= cfg_wdata;
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RUN;
			recv_q <= '0;
			sent_q <= '0;
		end else if (push) begin
			phase_q <= phase_d;
			recv_q <= recv_d;
			sent_q <= sent_d;
		end
	end

	assign recv_inc = (recv_q == 8'hFF) ? recv_q : recv_q + 8'd1;
	assign sent_add = {1'b0, sent_q} + 9'd4;
	assign fill_e = CmpW'(item.tx_fill);
	assign num_e = CmpW'(item.num_bytes);
	assign space_ok = (fill_e <= BufSize) && ((BufSize - fill_e) >= num_e);

	always_comb begin
		phase_d = phase_q;
		recv_d = recv_q;
		sent_d = sent_q;
		w = '0;
		w.status = STATUS_NONE;
		case (item.kind)
			KIND_RX: begin
				case (phase_q)
					PH_M_WAIT_SYNC: begin
						if (item.rx_byte == SYNC_BYTE) begin
							w.tx_valid = 1'b1;
							w.tx_bytes[0] = SYNC_BYTE;
							phase_d = PH_M_WAIT_ACK;
						end
					end
					PH_M_WAIT_ACK: begin
						if (item.rx_byte == ACK_BYTE) phase_d = PH_RUN;
					end
					PH_S_WAIT_SYNC: begin
						if (item.rx_byte == SYNC_BYTE) begin
							w.tx_valid = 1'b1;
							w.tx_bytes[0] = ACK_BYTE;
							phase_d = PH_RUN;
						end
					end
					default: begin
						if (item.rx_byte == SYNC_BYTE) begin
							recv_d = '0;
							w.status = STATUS_FRAMING;
						end else if (item.rx_byte == ACK_BYTE) begin
							sent_d = (sent_q > credit_limit_q) ? sent_q - credit_limit_q : '0;
						end else begin
							// ack back after every ack_every data bytes
							recv_d = recv_inc;
							if (recv_inc >= ack_every_q) begin
								recv_d = '0;
								w.tx_valid = 1'b1;
								w.tx_bytes[0] = ACK_BYTE;
							end
							w.data_valid = 1'b1;
							w.data = item.rx_byte;
							w.status = STATUS_OK;
						end
					end
				endcase
			end
			KIND_TX: begin
				w.tx_valid = 1'b1;
				w.tx_bytes[0] = item.cmd_header;
				w.tx_bytes[1] = item.cmd_byte1;
				w.tx_bytes[2] = item.cmd_byte2;
				w.tx_bytes[3] = item.cmd_byte3;
				w.multi = 1'b1;
				sent_d = sent_add[BYTE_W] ? 8'hFF : sent_add[BYTE_W-1:0];
			end
			KIND_QUERY: begin
				w.can_send = (sent_q < credit_limit_q) && space_ok;
			end
			KIND_IDLE: begin
				// resend sync while the master waits for ack or the slave waits for sync, and the link is quiet
				if ((phase_q == PH_M_WAIT_ACK || phase_q == PH_S_WAIT_SYNC) &&
					item.rx_empty && (item.tx_fill == '0)) begin
					w.tx_valid = 1'b1;
					w.tx_bytes[0] = SYNC_BYTE;
				end
			end
			KIND_SYNC: begin
				if (role_q) begin
					phase_d = PH_M_WAIT_SYNC;
				end else begin
					w.tx_valid = 1'b1;
					w.tx_bytes[0] = SYNC_BYTE;
					phase_d = PH_S_WAIT_SYNC;
				end
			end
			default: ;
		endcase
		w.synced = (phase_d == PH_RUN);
	end

endmodule

/* src/lcfc_queue.sv */
// lcfc_queue: short fifo of classified work between front and back
// depends on lcfc_pkg for work_t
module lcfc_queue import lcfc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  work_t push_data,
	output logic  full,
	input  logic  pop,
	output work_t head,
	output logic  empty
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	work_t           store_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full = (count_q == FullCnt);
	assign empty = (count_q == '0);
	assign head = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) store_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

/* src/lcfc_back.sv */
// lcfc_back: expands queued work into result items, one per cycle unless stalled
// depends on lcfc_pkg and lcfc_result_if
module lcfc_back import lcfc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  work_t  head,
	input  logic   empty,
	output logic   pop,
	lcfc_result_if.source result
);

	logic [1:0]          idx_q;
	logic                valid_q;
	logic                tx_valid_q;
	logic [BYTE_W-1:0]   tx_out_q;
	logic                data_valid_q;
	logic [BYTE_W-1:0]   data_out_q;
	logic [STATUS_W-1:0] status_q;
	logic                can_send_q;
	logic                synced_q;
	logic                last_q;
	logic                load;
	logic                is_last;

	assign load = !empty && (!valid_q || result.ready);
	assign is_last = !head.multi || (idx_q == 2'd3);
	assign pop = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) valid_q <= 1'b1;
			else if (result.ready) valid_q <= 1'b0;
			if (load) idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tx_valid_q <= head.tx_valid;
			tx_out_q <= head.tx_bytes[idx_q];
			data_valid_q <= head.data_valid;
			data_out_q <= head.data;
			status_q <= head.status;
			can_send_q <= head.can_send;
			synced_q <= head.synced;
			last_q <= is_last;
		end
	end

	assign result.valid = valid_q;
	assign result.tx_valid = tx_valid_q;
	assign result.tx_out = tx_out_q;
	assign result.data_valid = data_valid_q;
	assign result.data_out = data_out_q;
	assign result.status = status_q;
	assign result.can_send = can_send_q;
	assign result.synced = synced_q;
	assign result.last = last_q;

endmodule

/* src/lcfc_checker.sv */
// lcfc_checker: port-level checks of the link credit flow control block
// depends on lcfc_pkg; bound to link_credit_flow_control_unit
module lcfc_checker import lcfc_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                res_valid,
	input logic                res_ready,
	input logic                res_tx_valid,
	input logic [BYTE_W-1:0]   res_tx_out,
	input logic                res_data_valid,
	input logic [STATUS_W-1:0] res_status,
	input logic                res_can_send,
	input logic                res_synced,
	input logic                res_last
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_tx_out) && $stable(res_last))
		else $error("stalled result changed");

	// transmit bursts run back to back with no gap
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !res_last |=> res_valid && res_tx_valid)
		else $error("gap inside transmit burst");

	a_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data_valid |-> res_status == STATUS_OK && !res_can_send && res_last)
		else $error("data result with wrong status");

	a_query: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_can_send |-> !res_tx_valid && !res_data_valid && res_last)
		else $error("query answer mixed with traffic");

	a_framing: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == STATUS_FRAMING |-> res_synced && !res_tx_valid)
		else $error("framing status outside running phase");

endmodule

bind link_credit_flow_control_unit lcfc_checker u_lcfc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.res_tx_valid   (result.tx_valid),
	.res_tx_out     (result.tx_out),
	.res_data_valid (result.data_valid),
	.res_status     (result.status),
	.res_can_send   (result.can_send),
	.res_synced     (result.synced),
	.res_last       (result.last)
);

/* verif/tb_link_credit_flow_control_unit.sv */
`timescale 1ns / 100ps
// tb_link_credit_flow_control_unit: self-checking testbench of the link credit flow control unit
// depends on lcfc_pkg, lcfc_item_if, lcfc_result_if and the rtl of the block
module tb_link_credit_flow_control_unit;
	import lcfc_pkg::*;

	localparam int CLK_HALF = 4;
	localparam int STALL_LIMIT = 2000;	// cycles with no handshake on either channel
	localparam int HOLD_OFF = 80;		// long receiver stall, fills the work queue
	localparam int SETTLE = 8;		// quiet cycles before a register write and at the end
	localparam int RAND_PER_PHASE = 25;
	localparam int MAX_REPORTS = 10;

	// one input item, cmd[0] is the command header
	typedef struct packed {
		logic [KIND_W-1:0]                kind;
		logic [BYTE_W-1:0]                rx_byte;
		logic [CMD_BYTES-1:0][BYTE_W-1:0] cmd;
		logic [FILL_W-1:0]                num_bytes;
		logic [FILL_W-1:0]                tx_fill;
		logic                             rx_empty;
	} link_item_t;

	// one result item, in the order of the result channel fields
	typedef struct packed {
		logic                tx_valid;
		logic [BYTE_W-1:0]   tx_out;
		logic                data_valid;
		logic [BYTE_W-1:0]   data_out;
		logic [STATUS_W-1:0] status;
		logic                can_send;
		logic                synced;
		logic                last;
	} link_res_t;

	// link state model plus the queue of result items still owed by the block
	class credit_scoreboard;
		link_res_t expected_q[$];
		phase_t phase;
		logic [7:0] recv_count;
		logic [7:0] sent_count;
		logic role_master;
		logic [7:0] ack_every;
		logic [7:0] credit_limit;
		int mismatches;

		function new();
			phase = PH_RUN;
			recv_count = '0;
			sent_count = '0;
			role_master = 1'b0;
			ack_every = ACK_EVERY_RST;
			credit_limit = CREDIT_LIMIT_RST;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				CFG_ROLE_MASTER: role_master = value[0];
				CFG_ACK_EVERY: ack_every = value;
				CFG_CREDIT_LIMIT: credit_limit = value;
				default: ;
			endcase
		endfunction

		function link_res_t make_res(logic txv, logic [7:0] tx, logic dv, logic [7:0] d,
			logic [STATUS_W-1:0] st, logic cs);
			link_res_t r;
			r = '0;
			r.tx_valid = txv;
			r.tx_out = tx;
			r.data_valid = dv;
			r.data_out = d;
			r.status = st;
			r.can_send = cs;
			return r;
		endfunction

		function string show(link_res_t r);
			return $sformatf("tx %0b/%02h data %0b/%02h status %0d can_send %0b synced %0b last %0b",
				r.tx_valid, r.tx_out, r.data_valid, r.data_out, r.status, r.can_send,
				r.synced, r.last);
		endfunction

		function void note_item(link_item_t it);
			link_res_t res [CMD_BYTES];
			int n;
			int fill;
			logic ack_now;
			logic ok;
			n = 1;
			res[0] = make_res(1'b0, 8'h00, 1'b0, 8'h00, STATUS_NONE, 1'b0);
			case (it.kind)
				KIND_RX: begin
					case (phase)
						PH_M_WAIT_SYNC: begin
							// master answers the partner's sync with its own
							if (it.rx_byte == SYNC_BYTE) begin
								res[0] = make_res(1'b1, SYNC_BYTE, 1'b0, 8'h00, STATUS_NONE, 1'b0);
								phase = PH_M_WAIT_ACK;
							end
						end
						PH_M_WAIT_ACK: begin
							if (it.rx_byte == ACK_BYTE)
								phase = PH_RUN;
						end
						PH_S_WAIT_SYNC: begin
							// slave acks the partner's sync and the link is up
							if (it.rx_byte == SYNC_BYTE) begin
								res[0] = make_res(1'b1, ACK_BYTE, 1'b0, 8'h00, STATUS_NONE, 1'b0);
								phase = PH_RUN;
							end
						end
						default: begin
							if (it.rx_byte == SYNC_BYTE) begin
								// sync while running: framing, receive count restarts
								recv_count = '0;
								res[0] = make_res(1'b0, 8'h00, 1'b0, 8'h00, STATUS_FRAMING, 1'b0);
							end else if (it.rx_byte == ACK_BYTE) begin
								// ack returns credit, floor at zero
								sent_count = (sent_count > credit_limit) ?
									sent_count - credit_limit : 8'd0;
							end else begin
								if (recv_count != 8'hFF)
									recv_count = recv_count + 8'd1;
								ack_now = (recv_count >= ack_every);
								if (ack_now)
									recv_count = '0;
								res[0] = make_res(ack_now, ack_now ? ACK_BYTE : 8'h00, 1'b1,
									it.rx_byte, STATUS_OK, 1'b0);
							end
						end
					endcase
				end
				KIND_TX: begin
					for (int k = 0; k < CMD_BYTES; k++)
						res[k] = make_res(1'b1, it.cmd[k], 1'b0, 8'h00, STATUS_NONE, 1'b0);
					n = CMD_BYTES;
					sent_count = (sent_count > 8'd251) ? 8'd255 : sent_count + 8'd4;
				end
				KIND_QUERY: begin
					fill = int'(it.tx_fill);
					ok = (sent_count < credit_limit) && (fill <= TX_BUFFER_SIZE_DEF) &&
						(TX_BUFFER_SIZE_DEF - fill >= int'(it.num_bytes));
					res[0] = make_res(1'b0, 8'h00, 1'b0, 8'h00, STATUS_NONE, ok);
				end
				KIND_IDLE: begin
					// sync resend only while waiting and with nothing else on the link
					if ((phase == PH_M_WAIT_ACK || phase == PH_S_WAIT_SYNC) &&
						it.rx_empty && it.tx_fill == '0)
						res[0] = make_res(1'b1, SYNC_BYTE, 1'b0, 8'h00, STATUS_NONE, 1'b0);
				end
				KIND_SYNC: begin
					if (role_master) begin
						phase = PH_M_WAIT_SYNC;
					end else begin
						res[0] = make_res(1'b1, SYNC_BYTE, 1'b0, 8'h00, STATUS_NONE, 1'b0);
						phase = PH_S_WAIT_SYNC;
					end
				end
				default: ;
			endcase
			for (int k = 0; k < n; k++) begin
				res[k].synced = (phase == PH_RUN);
				res[k].last = (k == n - 1);
				expected_q.push_back(res[k]);
			end
		endfunction

		function void check_result(link_res_t got);
			link_res_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result item: %s", show(got));
				return;
			end
			want = expected_q.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("result mismatch\n  expected %s\n  actual   %s", show(want), show(got));
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	lcfc_item_if item_ch();
	lcfc_result_if result_ch();

	link_credit_flow_control_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.item      (item_ch),
		.result    (result_ch)
	);

	credit_scoreboard sb = new();
	logic steady = 1'b0;		// no idling on either side while set
	logic hold_req = 1'b0;		// asks the result side for one long stall
	logic cur_role = 1'b0;		// role currently programmed, shapes the handshakes

	always #CLK_HALF clk = ~clk;

	// ---------------------------------------------------------------- item side

	task automatic put_fields(link_item_t it);
		item_ch.kind <= it.kind;
		item_ch.rx_byte <= it.rx_byte;
		item_ch.cmd_header <= it.cmd[0];
		item_ch.cmd_byte1 <= it.cmd[1];
		item_ch.cmd_byte2 <= it.cmd[2];
		item_ch.cmd_byte3 <= it.cmd[3];
		item_ch.num_bytes <= it.num_bytes;
		item_ch.tx_fill <= it.tx_fill;
		item_ch.rx_empty <= it.rx_empty;
	endtask

	// offer one item after a random gap, hold it until taken, then predict
	task automatic send_item(link_item_t it);
		while (!steady && $urandom_range(0, 99) < 30) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		put_fields(it);
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		sb.note_item(it);
	endtask

	function automatic link_item_t plain_item(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] rx);
		link_item_t it;
		it = '0;
		it.kind = kind;
		it.rx_byte = rx;
		it.rx_empty = 1'b1;
		return it;
	endfunction

	// random item, weighted toward received bytes and link control bytes
	function automatic link_item_t rand_item();
		link_item_t it;
		int pick;
		it.cmd = $urandom;
		it.rx_byte = 8'($urandom_range(0, 255));
		pick = $urandom_range(0, 99);
		if (pick < 15)
			it.rx_byte = SYNC_BYTE;
		else if (pick < 30)
			it.rx_byte = ACK_BYTE;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			it.kind = KIND_RX;
		else if (pick < 60)
			it.kind = KIND_TX;
		else if (pick < 75)
			it.kind = KIND_QUERY;
		else if (pick < 87)
			it.kind = KIND_IDLE;
		else if (pick < 95)
			it.kind = KIND_SYNC;
		else
			it.kind = KIND_SYNC + 3'($urandom_range(1, 3));	// unused kinds
		// fill: zero, near the buffer edge or anything in 9 bits; size: mostly small, sometimes anything in 9 bits
		if ($urandom_range(0, 3) == 0)
			it.tx_fill = 9'($urandom_range(0, 511));
		else if ($urandom_range(0, 1) == 0)
			it.tx_fill = '0;
		else
			it.tx_fill = 9'($urandom_range(TX_BUFFER_SIZE_DEF - 8, TX_BUFFER_SIZE_DEF + 4));
		if ($urandom_range(0, 3) == 0)
			it.num_bytes = 9'($urandom_range(0, 511));
		else
			it.num_bytes = 9'($urandom_range(0, 16));
		it.rx_empty = ($urandom_range(0, 3) != 0);
		return it;
	endfunction

	// lower valid and wait until the block owes nothing more
	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// --------------------------------------------------------- register writes

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		sb.write_reg(idx, value);
	endtask

	task automatic set_config(logic role, logic [7:0] ack_n, logic [7:0] credit);
		wait_idle();
		write_reg(CFG_ROLE_MASTER, {7'b0, role});
		write_reg(CFG_ACK_EVERY, ack_n);
		write_reg(CFG_CREDIT_LIMIT, credit);
		cfg_we <= 1'b0;
		cur_role = role;
	endtask

	// ---------------------------------------------------------------- stimulus

	// edges of the fields and each corner of the link protocol, slave role
	task automatic run_directed();
		link_item_t it;
		send_item(plain_item(KIND_RX, 8'h00));		// data byte delivered
		send_item(plain_item(KIND_RX, 8'hFF));
		send_item(plain_item(KIND_RX, SYNC_BYTE));		// framing while running
		send_item(plain_item(KIND_RX, ACK_BYTE));		// ack with nothing sent, floor zero
		it = plain_item(KIND_TX, 8'h00);
		it.cmd = {8'h5A, 8'hA5, 8'h00, 8'hFF};
		send_item(it);
		send_item(plain_item(KIND_QUERY, 8'h00));		// room and credit, can send
		it = plain_item(KIND_QUERY, 8'h00);
		it.tx_fill = 9'(TX_BUFFER_SIZE_DEF);		// buffer exactly full, nothing wanted
		send_item(it);
		it.tx_fill = 9'(TX_BUFFER_SIZE_DEF + 1);	// fill beyond the buffer
		send_item(it);
		it.tx_fill = 9'h1FF;
		it.num_bytes = 9'h1FF;
		send_item(it);
		it.tx_fill = '0;
		it.num_bytes = 9'(TX_BUFFER_SIZE_DEF);
		send_item(it);
		it.num_bytes = 9'(TX_BUFFER_SIZE_DEF + 1);
		send_item(it);
		send_item(plain_item(KIND_IDLE, 8'h00));		// idle while running sends nothing
		for (int k = 1; k <= 3; k++)
			send_item(plain_item(KIND_SYNC + 3'(k), 8'h00));	// unused kinds
		send_item(plain_item(KIND_SYNC, 8'h00));		// slave starts with sync
		send_item(plain_item(KIND_IDLE, 8'h00));		// resend on idle
		it = plain_item(KIND_IDLE, 8'h00);
		it.rx_empty = 1'b0;				// received bytes pending, no resend
		send_item(it);
		it.rx_empty = 1'b1;
		it.tx_fill = 9'd1;				// transmit busy, no resend
		send_item(it);
		send_item(plain_item(KIND_RX, 8'h12));		// stray byte during sync is dropped
		send_item(plain_item(KIND_RX, ACK_BYTE));
		send_item(plain_item(KIND_RX, SYNC_BYTE));		// partner sync, ack back, link up
		it = plain_item(KIND_TX, 8'h00);
		it.cmd = {8'hFF, 8'h00, 8'hFF, 8'h00};
		send_item(it);
	endtask

	// random items with whole handshakes mixed in so the link comes up often
	task automatic run_random(int count);
		link_item_t it;
		int done;
		done = 0;
		while (done < count) begin
			if ($urandom_range(0, 99) < 12) begin
				it = rand_item();
				it.kind = KIND_SYNC;
				send_item(it);
				it = rand_item();
				if (cur_role) begin
					it.kind = KIND_RX;
					it.rx_byte = SYNC_BYTE;
					send_item(it);
				end
				it.kind = KIND_IDLE;
				it.rx_empty = 1'b1;
				it.tx_fill = '0;
				send_item(it);
				it.kind = KIND_RX;
				it.rx_byte = cur_role ? ACK_BYTE : SYNC_BYTE;
				send_item(it);
				done += cur_role ? 4 : 3;
			end else begin
				send_item(rand_item());
				done++;
			end
		end
	endtask

	// ------------------------------------------------------------- result side

	// checks each taken result, then picks ready for the next cycle
	initial begin : result_sink
		int hold_left;
		link_res_t got;
		hold_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				got = {result_ch.tx_valid, result_ch.tx_out, result_ch.data_valid,
					result_ch.data_out, result_ch.status, result_ch.can_send,
					result_ch.synced, result_ch.last};
				sb.check_result(got);
			end
			if (hold_req) begin
				hold_left = HOLD_OFF;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else if (steady) begin
				result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= 30);
			end
		end
	end

	// ends the run if neither channel moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL link_credit_flow_control_unit");
		$finish;
	end

	// ------------------------------------------------------------------ main

	initial begin : main_seq
		int failures;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= '0;
		cfg_wdata <= '0;
		item_ch.valid <= 1'b0;
		put_fields('0);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: slave, ack and credit at 16
		run_directed();

		// master, tightest credit and an ack per byte; receiver stalls long once
		set_config(1'b1, 8'd1, 8'd1);
		hold_req = 1'b1;
		run_random(RAND_PER_PHASE);

		// slave at the widest settings, both sides streaming with no gaps
		set_config(1'b0, 8'd255, 8'd255);
		steady = 1'b1;
		run_random(RAND_PER_PHASE);
		steady = 1'b0;

		// master with ack every zero: an ack after every data byte
		set_config(1'b1, 8'd0, 8'd4);
		run_random(RAND_PER_PHASE);

		// drain, then give stray result items a chance to show up
		wait_idle();
		repeat (SETTLE) @(posedge clk);
		failures = sb.mismatches + sb.expected_q.size();
		if (failures == 0)
			$display("PASS link_credit_flow_control_unit");
		else
			$display("FAIL link_credit_flow_control_unit");
		$finish;
	end

endmodule
